[rtl/core/bounded_stack_with_reverse_dedup_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bounded stack
// Immediate-implication and next-cycle-implication checks, clocked on clk and
// disabled while rst_n is low. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STACK_WITH_REVERSE_DEDUP_MACROS_SVH
`define BOUNDED_STACK_WITH_REVERSE_DEDUP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent
`define BSRD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsrd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define BSRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsrd: next-cycle check failed");

`else

`define BSRD_ASSERT_NOW(label, ante, cons)
`define BSRD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/core/bsrd_pkg.sv]
// ----------------------------------------------------------------------------
// bsrd_pkg
// Shared constants, codes and types of the bounded stack.
// ----------------------------------------------------------------------------
package bsrd_pkg;

  // Default number of stack entries
  localparam int DEPTH_DEF = 16;

  // Word field widths
  localparam int MODE_W   = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int DEPTH_W  = 5;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SHOW  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REV   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DEDUP = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Flags from the shared compare unit
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

[rtl/core/bsrd_if.sv]
// ----------------------------------------------------------------------------
// bsrd_if
// Valid/ready channels of the bounded stack: command words in, result words out.
// ----------------------------------------------------------------------------
interface bsrd_in_if;
  logic                                valid;
  logic                                ready;
  logic [bsrd_pkg::MODE_W-1:0]         mode;
  logic signed [bsrd_pkg::DATA_W-1:0]  push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface bsrd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bsrd_pkg::DATA_W-1:0]  value;
  logic [bsrd_pkg::STATUS_W-1:0]       status;
  logic                                last;
  logic [bsrd_pkg::DEPTH_W-1:0]        depth;

  modport source (output valid, output value, output status, output last,
                  output depth, input ready);
  modport sink   (input valid, input value, input status, input last,
                  input depth, output ready);
endinterface

[rtl/core/bounded_stack_with_reverse_dedup.sv]
// ----------------------------------------------------------------------------
// bounded_stack_with_reverse_dedup
// LIFO stack of signed 32-bit words, DEPTH entries, with show, reverse,
// clear and duplicate removal, run by a sequencer around one compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries command words (mode, push_value); out_ch carries result
//   words (value, status, last, depth). A word moves when valid and ready are
//   both high. Every command gives one result word, except show on a
//   non-empty stack, which gives one word per entry, top first, with last set
//   on the bottom entry.
// Sequencing (n = entries held):
//   push, clear, empty/full reports, unused modes: result registered from
//   idle at accept. pop: entry read, then S_POP. show: S_SHOW_RD then
//   S_SHOW_OUT per entry. reverse: S_REV_A, S_REV_B, S_REV_C, S_REV_D per
//   swapped pair, then S_REV_A to finish. dedup: S_DD_RD and S_DD_LD per
//   entry read, S_DD_SCAN and S_DD_CMP per compare against the kept list
//   (up to n*(n-1)/2 compares), S_DD_SCAN to append each kept value and
//   S_CP_RD, S_CP_WR to copy it back. These states follow from the single
//   read port of each entry RAM and the one shared compare unit. A new command
//   is taken only when the sequencer is idle and the output register is empty or being taken.
// Reset: synchronous, active low; empties the stack and the output register.
//   RAM contents are not cleared; only entries below the count are ever read.
// Stall: while out_ch.ready is low the result word holds and no command or
//   further show entry advances.
// ----------------------------------------------------------------------------
`include "bounded_stack_with_reverse_dedup_macros.svh"

module bounded_stack_with_reverse_dedup #(
  parameter int DEPTH = bsrd_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  bsrd_in_if.sink           in_ch,
  bsrd_out_if.source        out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = bsrd_pkg::DATA_W;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_POP      = 14'b00000000000010,
    S_SHOW_RD  = 14'b00000000000100,
    S_SHOW_OUT = 14'b00000000001000,
    S_REV_A    = 14'b00000000010000,
    S_REV_B    = 14'b00000000100000,
    S_REV_C    = 14'b00000001000000,
    S_REV_D    = 14'b00000010000000,
    S_DD_RD    = 14'b00000100000000,
    S_DD_LD    = 14'b00001000000000,
    S_DD_SCAN  = 14'b00010000000000,
    S_DD_CMP   = 14'b00100000000000,
    S_CP_RD    = 14'b01000000000000,
    S_CP_WR    = 14'b10000000000000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [CW-1:0]                  i_r, i_nxt;
  logic [CW-1:0]                  j_r, j_nxt;
  logic [CW-1:0]                  nk_r, nk_nxt;
  logic [AW-1:0]                  lo_r, lo_nxt;
  logic [AW-1:0]                  hi_r, hi_nxt;
  logic [DW-1:0]                  tmp_r, tmp_nxt;
  logic [DW-1:0]                  v_r, v_nxt;

  logic                           out_valid_r;
  logic [DW-1:0]                  out_value_r;
  logic [bsrd_pkg::STATUS_W-1:0]  out_status_r;
  logic                           out_last_r;
  logic [bsrd_pkg::DEPTH_W-1:0]   out_depth_r;

  logic                           out_load;
  logic [DW-1:0]                  ld_value;
  logic [bsrd_pkg::STATUS_W-1:0]  ld_status;
  logic                           ld_last;

  logic                           out_free;
  logic                           in_acc;
  logic                           push_taken;
  logic                           is_empty;
  logic                           is_full;
  logic [CW-1:0]                  cnt_m1;
  logic [CW-1:0]                  i_m1;
  logic [CW-1:0]                  cp_idx;

  logic                           e_we, e_re;
  logic [AW-1:0]                  e_waddr, e_raddr;
  logic [DW-1:0]                  e_wdata, e_rdata;
  logic                           k_we, k_re;
  logic [AW-1:0]                  k_waddr, k_raddr;
  logic [DW-1:0]                  k_wdata, k_rdata;

  logic [DW-1:0]                  cmp_a, cmp_b;
  bsrd_pkg::cmp_res_t             cmp_res;

  // Entry store and kept-value list for dedup
  bsrd_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_entries (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  bsrd_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_kept (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .re    (k_re),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  bsrd_cmp #(.W(DW)) u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  // Handshake and helpers
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_empty    = (count_r == '0);
  assign is_full     = (count_r == CW'(DEPTH));
  assign push_taken  = in_acc && (in_ch.mode == bsrd_pkg::MODE_PUSH) && !is_full;
  assign cnt_m1      = count_r - CW'(1);
  assign i_m1        = i_r - CW'(1);
  assign cp_idx      = nk_r - j_r - CW'(1);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    nk_nxt    = nk_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    tmp_nxt   = tmp_r;
    v_nxt     = v_r;
    e_we      = 1'b0;
    e_waddr   = '0;
    e_wdata   = '0;
    e_re      = 1'b0;
    e_raddr   = '0;
    k_we      = 1'b0;
    k_waddr   = '0;
    k_wdata   = '0;
    k_re      = 1'b0;
    k_raddr   = '0;
    cmp_a     = '0;
    cmp_b     = '0;
    out_load  = 1'b0;
    ld_value  = '0;
    ld_status = bsrd_pkg::ST_OK;
    ld_last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.mode)
            bsrd_pkg::MODE_PUSH: begin
              out_load = 1'b1;
              if (is_full) begin
                ld_status = bsrd_pkg::ST_FULL;
              end else begin
                e_we      = 1'b1;
                e_waddr   = count_r[AW-1:0];
                e_wdata   = in_ch.push_value;
                count_nxt = count_r + CW'(1);
              end
            end
            bsrd_pkg::MODE_POP: begin
              if (is_empty) begin
                out_load  = 1'b1;
                ld_status = bsrd_pkg::ST_EMPTY;
              end else begin
                e_re      = 1'b1;
                e_raddr   = cnt_m1[AW-1:0];
                count_nxt = cnt_m1;
                state_nxt = S_POP;
              end
            end
            bsrd_pkg::MODE_SHOW: begin
              if (is_empty) begin
                out_load  = 1'b1;
                ld_status = bsrd_pkg::ST_EMPTY;
              end else begin
                i_nxt     = count_r;
                state_nxt = S_SHOW_RD;
              end
            end
            bsrd_pkg::MODE_REV: begin
              if (is_empty) begin
                out_load  = 1'b1;
                ld_status = bsrd_pkg::ST_EMPTY;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = cnt_m1[AW-1:0];
                state_nxt = S_REV_A;
              end
            end
            bsrd_pkg::MODE_CLEAR: begin
              out_load = 1'b1;
              if (is_empty) begin
                ld_status = bsrd_pkg::ST_EMPTY;
              end else begin
                count_nxt = '0;
              end
            end
            bsrd_pkg::MODE_DEDUP: begin
              if (is_empty) begin
                out_load  = 1'b1;
                ld_status = bsrd_pkg::ST_EMPTY;
              end else begin
                i_nxt     = count_r;
                nk_nxt    = '0;
                state_nxt = S_DD_RD;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      // Deliver the popped word
      S_POP: begin
        out_load  = 1'b1;
        ld_value  = e_rdata;
        state_nxt = S_IDLE;
      end

      // Walk entries from the top, one word per output slot
      S_SHOW_RD: begin
        e_re      = 1'b1;
        e_raddr   = i_m1[AW-1:0];
        state_nxt = S_SHOW_OUT;
      end
      S_SHOW_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_value = e_rdata;
          ld_last  = (i_r == CW'(1));
          i_nxt    = i_m1;
          if (i_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SHOW_RD;
          end
        end
      end

      // Swap lo and hi until the pointers meet
      S_REV_A: begin
        cmp_a = DW'(lo_r);
        cmp_b = DW'(hi_r);
        if (cmp_res.lt) begin
          e_re      = 1'b1;
          e_raddr   = lo_r;
          state_nxt = S_REV_B;
        end else begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_REV_B: begin
        e_re      = 1'b1;
        e_raddr   = hi_r;
        tmp_nxt   = e_rdata;
        state_nxt = S_REV_C;
      end
      S_REV_C: begin
        e_we      = 1'b1;
        e_waddr   = lo_r;
        e_wdata   = e_rdata;
        state_nxt = S_REV_D;
      end
      S_REV_D: begin
        e_we      = 1'b1;
        e_waddr   = hi_r;
        e_wdata   = tmp_r;
        lo_nxt    = lo_r + AW'(1);
        hi_nxt    = hi_r - AW'(1);
        state_nxt = S_REV_A;
      end

      // Take the next entry from the top, or start copying back
      S_DD_RD: begin
        if (i_r == '0) begin
          j_nxt     = '0;
          state_nxt = S_CP_RD;
        end else begin
          e_re      = 1'b1;
          e_raddr   = i_m1[AW-1:0];
          i_nxt     = i_m1;
          state_nxt = S_DD_LD;
        end
      end
      S_DD_LD: begin
        v_nxt     = e_rdata;
        j_nxt     = '0;
        state_nxt = S_DD_SCAN;
      end
      // Scan kept list; append the value when no match was found
      S_DD_SCAN: begin
        if (j_r == nk_r) begin
          k_we      = 1'b1;
          k_waddr   = nk_r[AW-1:0];
          k_wdata   = v_r;
          nk_nxt    = nk_r + CW'(1);
          state_nxt = S_DD_RD;
        end else begin
          k_re      = 1'b1;
          k_raddr   = j_r[AW-1:0];
          state_nxt = S_DD_CMP;
        end
      end
      S_DD_CMP: begin
        cmp_a = k_rdata;
        cmp_b = v_r;
        if (cmp_res.eq) begin
          state_nxt = S_DD_RD;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_DD_SCAN;
        end
      end

      // Copy kept list back, bottom entry first
      S_CP_RD: begin
        if (j_r == nk_r) begin
          count_nxt = nk_r;
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          k_re      = 1'b1;
          k_raddr   = cp_idx[AW-1:0];
          state_nxt = S_CP_WR;
        end
      end
      S_CP_WR: begin
        e_we      = 1'b1;
        e_waddr   = j_r[AW-1:0];
        e_wdata   = k_rdata;
        j_nxt     = j_r + CW'(1);
        state_nxt = S_CP_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and result word
  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    nk_r  <= nk_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    tmp_r <= tmp_nxt;
    v_r   <= v_nxt;
    if (out_load) begin
      out_value_r  <= ld_value;
      out_status_r <= ld_status;
      out_last_r   <= ld_last;
      out_depth_r  <= bsrd_pkg::DEPTH_W'(count_nxt);
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;
  assign out_ch.last   = out_last_r;
  assign out_ch.depth  = out_depth_r;

  // Checks
  `BSRD_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `BSRD_ASSERT_NOW(a_load_when_free, out_load, out_free)
  `BSRD_ASSERT_NEXT(a_push_grows, push_taken, count_r == $past(count_r) + CW'(1))
  `BSRD_ASSERT_NOW(a_swap_order, state_r == S_REV_D, lo_r < hi_r)
  `BSRD_ASSERT_NOW(a_kept_bound, state_r == S_DD_SCAN || state_r == S_CP_RD, nk_r <= count_r)

endmodule

[rtl/core/bsrd_ram.sv]
// ----------------------------------------------------------------------------
// bsrd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsrd_ram #(
  parameter int WIDTH = bsrd_pkg::DATA_W,
  parameter int DEPTH = bsrd_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/bsrd_cmp.sv]
// ----------------------------------------------------------------------------
// bsrd_cmp
// Shared compare unit: equality of stored words and unsigned ordering of
// swap pointers.
// ----------------------------------------------------------------------------
module bsrd_cmp #(
  parameter int W = bsrd_pkg::DATA_W
) (
  input  logic [W-1:0]        a,
  input  logic [W-1:0]        b,
  output bsrd_pkg::cmp_res_t  res
);

  // Compare both ways at once
  always_comb begin
    res.eq = (a == b);
    res.lt = (a < b);
  end

endmodule

[tb/tb_bounded_stack_with_reverse_dedup.sv]
// ----------------------------------------------------------------------------
// tb_bounded_stack_with_reverse_dedup
// Self-checking bench for the bounded LIFO stack. Command words go in through
// a valid/ready channel with random gaps. The bench tracks its own copy of the
// stack and queues the result words each command should give. A separate
// process takes result words with random stalls and compares every field
// against the oldest queued word. The run covers operations on an empty stack,
// field extremes, a full stack held up by a long output stall, and a long
// random mix.
// ----------------------------------------------------------------------------
module tb_bounded_stack_with_reverse_dedup;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH        = bsrd_pkg::DEPTH_DEF;
  localparam int          DW           = bsrd_pkg::DATA_W;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned TAIL_CYCLES  = 400;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned RANDOM_WORDS = 110;
  localparam int unsigned PRINT_CAP    = 40;

  // Modes outside the defined set, which the block must ignore
  localparam logic [bsrd_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [bsrd_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;

  typedef struct packed {
    logic signed [bsrd_pkg::DATA_W-1:0] value;
    logic [bsrd_pkg::STATUS_W-1:0]      status;
    logic                               last;
    logic [bsrd_pkg::DEPTH_W-1:0]       depth;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bsrd_in_if  in_ch ();
  bsrd_out_if out_ch ();

  bounded_stack_with_reverse_dedup #(
    .DEPTH(DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Predicted stack contents and the result words still owed
  logic signed [DW-1:0] model_entries [DEPTH];
  int unsigned          model_count;
  stack_result_t        pending_results [$];

  // Run controls and tallies
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned hold_off_req = 0;
  int unsigned err_count = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned full_reports = 0;
  int unsigned empty_reports = 0;
  int unsigned dedup_passes = 0;
  int unsigned cycle_count = 0;

  // Generate the 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_count,
               pending_results.size());
      $display("[bounded_stack_with_reverse_dedup] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_CAP)
      $display("%0t ns: mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Queue one result word at the current depth
  task automatic owe_word(input logic signed [DW-1:0] value,
                          input logic [bsrd_pkg::STATUS_W-1:0] status, input logic last);
    stack_result_t r;
    r.value  = value;
    r.status = status;
    r.last   = last;
    r.depth  = model_count[bsrd_pkg::DEPTH_W-1:0];
    pending_results.insert(pending_results.size(), r);
    if (status == bsrd_pkg::ST_FULL)  full_reports++;
    if (status == bsrd_pkg::ST_EMPTY) empty_reports++;
  endtask

  // Apply one accepted command to the predicted stack
  task automatic predict_stack_op(input logic [bsrd_pkg::MODE_W-1:0] mode,
                                  input logic signed [DW-1:0] pv);
    logic signed [DW-1:0] kept [DEPTH];
    logic signed [DW-1:0] swap;
    int unsigned          nk;
    int unsigned          lo;
    int unsigned          hi;
    bit                   seen;
    case (mode)
      bsrd_pkg::MODE_PUSH: begin
        if (model_count >= DEPTH) begin
          owe_word('0, bsrd_pkg::ST_FULL, 1'b1);
        end else begin
          model_entries[model_count] = pv;
          model_count++;
          owe_word('0, bsrd_pkg::ST_OK, 1'b1);
        end
      end
      bsrd_pkg::MODE_POP: begin
        if (model_count == 0) begin
          owe_word('0, bsrd_pkg::ST_EMPTY, 1'b1);
        end else begin
          model_count--;
          owe_word(model_entries[model_count], bsrd_pkg::ST_OK, 1'b1);
        end
      end
      bsrd_pkg::MODE_SHOW: begin
        if (model_count == 0) begin
          owe_word('0, bsrd_pkg::ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < model_count; i++)
            owe_word(model_entries[model_count-1-i], bsrd_pkg::ST_OK,
                     i + 1 == model_count);
        end
      end
      bsrd_pkg::MODE_REV, bsrd_pkg::MODE_CLEAR, bsrd_pkg::MODE_DEDUP: begin
        if (model_count == 0) begin
          owe_word('0, bsrd_pkg::ST_EMPTY, 1'b1);
        end else begin
          if (mode == bsrd_pkg::MODE_REV) begin
            lo = 0;
            hi = model_count - 1;
            while (lo < hi) begin
              swap              = model_entries[lo];
              model_entries[lo] = model_entries[hi];
              model_entries[hi] = swap;
              lo++;
              hi--;
            end
          end else if (mode == bsrd_pkg::MODE_CLEAR) begin
            model_count = 0;
          end else begin
            // keep first occurrences walking down from the top
            nk = 0;
            for (int i = model_count; i > 0; i--) begin
              seen = 1'b0;
              for (int j = 0; j < nk; j++)
                if (kept[j] == model_entries[i-1]) seen = 1'b1;
              if (!seen) begin
                kept[nk] = model_entries[i-1];
                nk++;
              end
            end
            for (int i = 0; i < nk; i++)
              model_entries[i] = kept[nk-1-i];
            model_count = nk;
            dedup_passes++;
          end
          owe_word('0, bsrd_pkg::ST_OK, 1'b1);
        end
      end
      default: owe_word('0, bsrd_pkg::ST_OK, 1'b1);
    endcase
  endtask

  // Offer one command word; return at the edge that takes it, valid left high
  task automatic send_word(input logic [bsrd_pkg::MODE_W-1:0] mode,
                           input logic signed [DW-1:0] pv);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.push_value <= pv;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    words_sent++;
    predict_stack_op(mode, pv);
  endtask

  // Drop valid and wait until every owed word has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Half the values come from a tiny pool so repeats are common
  function automatic logic signed [DW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return $signed($urandom_range(0, 3)) - 2;
    if (r == 5) return $signed({1'b1, {(DW-1){1'b0}}});
    if (r == 6) return $signed({1'b0, {(DW-1){1'b1}}});
    return $signed($urandom);
  endfunction

  function automatic logic [bsrd_pkg::MODE_W-1:0] pick_mode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 42) return bsrd_pkg::MODE_PUSH;
    if (r < 60) return bsrd_pkg::MODE_POP;
    if (r < 72) return bsrd_pkg::MODE_SHOW;
    if (r < 81) return bsrd_pkg::MODE_REV;
    if (r < 92) return bsrd_pkg::MODE_DEDUP;
    if (r < 96) return bsrd_pkg::MODE_CLEAR;
    if (r < 98) return MODE_SPARE6;
    return MODE_SPARE7;
  endfunction

  // Take result words, with random stalls and requested long hold-offs
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_off_req != 0) begin
        stall        = hold_off_req;
        hold_off_req = 0;
      end else begin
        stall = stalls_on ? $urandom_range(0, 7) : 0;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
    end
  end

  // Compare every taken result word against the oldest owed word
  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unowed word value=%0d status=%0d last=%0b depth=%0d",
                                  out_ch.value, out_ch.status, out_ch.last,
                                  out_ch.depth));
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (out_ch.value !== want.value)
          report_mismatch($sformatf("value %0d, want %0d", out_ch.value, want.value));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.status));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_ch.last, want.last));
        if (out_ch.depth !== want.depth)
          report_mismatch($sformatf("depth %0d, want %0d", out_ch.depth, want.depth));
      end
    end
  end

  // Every operation but push on an empty stack, ignored modes included
  task automatic test_empty_stack();
    send_word(bsrd_pkg::MODE_POP, '0);
    send_word(bsrd_pkg::MODE_SHOW, '0);
    send_word(bsrd_pkg::MODE_REV, '0);
    send_word(bsrd_pkg::MODE_CLEAR, '0);
    send_word(bsrd_pkg::MODE_DEDUP, '0);
    send_word(MODE_SPARE6, '0);
    send_word(MODE_SPARE7, -1);
    drain_results();
  endtask

  // Extreme values, reorder, dedup with deep repeats, then clear
  task automatic test_extremes_and_reorder();
    send_word(bsrd_pkg::MODE_PUSH, $signed({1'b1, {(DW-1){1'b0}}}));
    send_word(bsrd_pkg::MODE_PUSH, $signed({1'b0, {(DW-1){1'b1}}}));
    send_word(bsrd_pkg::MODE_PUSH, '0);
    send_word(bsrd_pkg::MODE_PUSH, -1);
    send_word(bsrd_pkg::MODE_SHOW, '0);
    send_word(bsrd_pkg::MODE_REV, '0);
    send_word(bsrd_pkg::MODE_SHOW, '0);
    send_word(bsrd_pkg::MODE_PUSH, -1);
    send_word(bsrd_pkg::MODE_PUSH, '0);
    send_word(MODE_SPARE6, '0);
    send_word(bsrd_pkg::MODE_DEDUP, '0);
    send_word(bsrd_pkg::MODE_SHOW, '0);
    send_word(bsrd_pkg::MODE_POP, '0);
    send_word(bsrd_pkg::MODE_CLEAR, '0);
    send_word(bsrd_pkg::MODE_POP, '0);
    drain_results();
  endtask

  // Fill past capacity back to back while the receiver holds off
  task automatic test_full_under_backpressure();
    gaps_on      = 1'b0;
    hold_off_req = HOLD_CYCLES;
    send_word(bsrd_pkg::MODE_CLEAR, '0);
    for (int i = 0; i <= DEPTH; i++)
      send_word(bsrd_pkg::MODE_PUSH, pick_value());
    send_word(bsrd_pkg::MODE_SHOW, '0);
    send_word(bsrd_pkg::MODE_DEDUP, '0);
    send_word(bsrd_pkg::MODE_SHOW, '0);
    send_word(bsrd_pkg::MODE_POP, '0);
    drain_results();
    gaps_on = 1'b1;
  endtask

  // Long random mix, with stretches where neither side idles
  task automatic test_random_mix();
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 25 == 0) begin
        gaps_on   = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
      end
      send_word(pick_mode(), pick_value());
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    drain_results();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = bsrd_pkg::MODE_PUSH;
    in_ch.push_value = '0;
    model_count      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stack();
    test_extremes_and_reorder();
    test_full_under_backpressure();
    test_random_mix();

    // let any stray word show up before the final check
    repeat (TAIL_CYCLES) @(posedge clk);
    while (pending_results.size() != 0) begin
      void'(pending_results.pop_front());
      report_mismatch("owed word never arrived");
    end

    $display("covered %0d commands and %0d result words checked", words_sent,
             words_checked);
    $display("hit %0d full reports, %0d empty reports, %0d dedup passes", full_reports,
             empty_reports, dedup_passes);
    if (err_count == 0) begin
      $display("[bounded_stack_with_reverse_dedup] OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("[bounded_stack_with_reverse_dedup] ERROR");
    end
    $finish;
  end

endmodule

[bounded_stack_with_reverse_dedup.f]
+incdir+rtl/core
rtl/core/bsrd_pkg.sv
rtl/core/bsrd_if.sv
rtl/core/bsrd_ram.sv
rtl/core/bsrd_cmp.sv
rtl/core/bounded_stack_with_reverse_dedup.sv
tb/tb_bounded_stack_with_reverse_dedup.sv
